// File: src/tlge_pkg.sv
// ----------------------------------------------------------------------------
// tlge_pkg
// Shared types, codes and constants of the toroidal life grid engine.
// ----------------------------------------------------------------------------
package tlge_pkg;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 6;
  localparam int SIZE_W      = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CHANGE_W    = 13;
  localparam int GEN_W       = 32;

  localparam int MIN_SIZE    = 3;
  localparam int BIRTH_COUNT = 3;
  localparam int KEEP_COUNT  = 2;

  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STEP   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  row_index;
    logic [INDEX_W-1:0]  column_index;
    logic                cell_live;
  } item_t;

  typedef struct packed {
    logic                cell_value;
    logic [GEN_W-1:0]    generation_count;
    logic                stable;
    logic                grid_empty;
    logic [CHANGE_W-1:0] changed_cells;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CELL_RD, S_CELL_WR, S_G_RD_LAST, S_G_RD_FIRST, S_G_CUR,
    S_G_RD_NEXT, S_G_CALC, S_G_COUNT, S_G_FINISH, S_SC_RD, S_SC_CHK, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_CELL_RD, OP_CELL_WR, OP_G_RD_LAST,
    OP_G_RD_FIRST, OP_G_CUR, OP_G_RD_NEXT, OP_G_CALC, OP_G_COUNT, OP_G_FINISH,
    OP_SC_RD, OP_SC_CHK, OP_EMIT
  } op_t;

  typedef struct packed {
    logic last_row;
    logic last_clear;
    logic last_col;
    logic out_free;
  } status_t;

endpackage

// File: src/tlge_ctrl.sv
// ----------------------------------------------------------------------------
// tlge_ctrl
// Sequencer that walks the datapath through clearing, cell access,
// generation steps and the live cell scan.
// ----------------------------------------------------------------------------
module tlge_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic [tlge_pkg::ACTION_W-1:0] item_action,
  output logic                          item_ready,
  input  tlge_pkg::status_t             status,
  output tlge_pkg::op_t                 op
);
  import tlge_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:      if (status.last_clear) state_next = S_IDLE;
      S_IDLE: begin
        if (item_valid) begin
          unique case (item_action) inside
            ACT_WRITE, ACT_READ: state_next = S_CELL_RD;
            ACT_STEP:            state_next = S_G_RD_LAST;
            default:             state_next = S_SC_RD;
          endcase
        end
      end
      S_CELL_RD:    state_next = S_CELL_WR;
      S_CELL_WR:    state_next = S_SC_RD;
      S_G_RD_LAST:  state_next = S_G_RD_FIRST;
      S_G_RD_FIRST: state_next = S_G_CUR;
      S_G_CUR:      state_next = S_G_RD_NEXT;
      S_G_RD_NEXT:  state_next = S_G_CALC;
      S_G_CALC:     state_next = S_G_COUNT;
      S_G_COUNT: begin
        if (status.last_col) begin
          state_next = status.last_row ? S_G_FINISH : S_G_RD_NEXT;
        end
      end
      S_G_FINISH:   state_next = S_SC_RD;
      S_SC_RD:      state_next = S_SC_CHK;
      S_SC_CHK:     state_next = status.last_row ? S_EMIT : S_SC_RD;
      S_EMIT:       if (status.out_free) state_next = S_IDLE;
      default:      state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    op         = OP_NONE;
    unique case (state)
      S_CLEAR:      op = OP_CLEAR;
      S_IDLE: begin
        item_ready = 1'b1;
        op         = item_valid ? OP_ACCEPT : OP_NONE;
      end
      S_CELL_RD:    op = OP_CELL_RD;
      S_CELL_WR:    op = OP_CELL_WR;
      S_G_RD_LAST:  op = OP_G_RD_LAST;
      S_G_RD_FIRST: op = OP_G_RD_FIRST;
      S_G_CUR:      op = OP_G_CUR;
      S_G_RD_NEXT:  op = OP_G_RD_NEXT;
      S_G_CALC:     op = OP_G_CALC;
      S_G_COUNT:    op = OP_G_COUNT;
      S_G_FINISH:   op = OP_G_FINISH;
      S_SC_RD:      op = OP_SC_RD;
      S_SC_CHK:     op = OP_SC_CHK;
      S_EMIT:       op = OP_EMIT;
      default:      op = OP_NONE;
    endcase
  end

endmodule

// File: src/tlge_datapath.sv
// ----------------------------------------------------------------------------
// tlge_datapath
// Row-wide grid memory, row registers for the generation step, counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module tlge_datapath #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlge_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlge_pkg::SIZE_W-1:0]      cfg_data,
  input  tlge_pkg::item_t                  item,
  input  tlge_pkg::op_t                    op,
  output tlge_pkg::status_t                status,
  output logic                             result_valid,
  input  logic                             result_ready,
  output tlge_pkg::result_t                result
);
  import tlge_pkg::*;

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLUMNS + 1);
  localparam int CHW = $clog2(MAX_ROWS * MAX_COLUMNS + 1);

  logic [MAX_COLUMNS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rd_data;
  logic                   mem_re, mem_we;
  logic [RIW-1:0]         mem_ra, mem_wa;
  logic [MAX_COLUMNS-1:0] mem_wd;

  logic [SIZE_W-1:0]      row_count, column_count;
  logic [NRW-1:0]         nr;
  logic [NCW-1:0]         nc;
  logic [RIW-1:0]         nrm1;
  logic [CIW-1:0]         ncm1;
  logic [MAX_COLUMNS-1:0] col_mask;

  item_t                  cur_item;
  logic                   in_grid;
  logic [RIW-1:0]         row_cnt;
  logic [CIW-1:0]         col_cnt;
  logic [MAX_COLUMNS-1:0] up_row, cur_row, first_row, chg_sr;
  logic [MAX_COLUMNS-1:0] dn_row, new_row, cell_row;
  logic [CHW-1:0]         chg_cnt, last_change;
  logic [GEN_W-1:0]       gen_cnt;
  logic                   stable_latch, any_live, cell_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= SIZE_W'(64);
      column_count <= SIZE_W'(64);
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROW_COUNT)    row_count    <= cfg_data;
      if (cfg_index == REG_COLUMN_COUNT) column_count <= cfg_data;
    end
  end

  // Sizes out of range act as the nearest legal size.
  always_comb begin
    if (row_count < SIZE_W'(MIN_SIZE))       nr = NRW'(MIN_SIZE);
    else if (32'(row_count) > 32'(MAX_ROWS)) nr = NRW'(MAX_ROWS);
    else                                     nr = NRW'(row_count);
    if (column_count < SIZE_W'(MIN_SIZE))          nc = NCW'(MIN_SIZE);
    else if (32'(column_count) > 32'(MAX_COLUMNS)) nc = NCW'(MAX_COLUMNS);
    else                                           nc = NCW'(column_count);
    nrm1 = RIW'(nr - NRW'(1));
    ncm1 = CIW'(nc - NCW'(1));
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = NCW'(c) < nc;
    end
  end

  assign in_grid = (32'(cur_item.row_index) < 32'(nr)) &&
                   (32'(cur_item.column_index) < 32'(nc));

  assign status.last_row   = row_cnt == nrm1;
  assign status.last_clear = row_cnt == RIW'(MAX_ROWS - 1);
  assign status.last_col   = col_cnt == ncm1;
  assign status.out_free   = !result_valid || result_ready;

  // One generation of a row from the original rows above, at and below it.
  assign dn_row = status.last_row ? first_row : rd_data;

  always_comb begin
    logic [3:0] n;
    logic       ul, ur, cl, cr, dl, dr;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (c == 0) begin
        ul = up_row[ncm1];
        cl = cur_row[ncm1];
        dl = dn_row[ncm1];
      end else begin
        ul = up_row[(c + MAX_COLUMNS - 1) % MAX_COLUMNS];
        cl = cur_row[(c + MAX_COLUMNS - 1) % MAX_COLUMNS];
        dl = dn_row[(c + MAX_COLUMNS - 1) % MAX_COLUMNS];
      end
      if (CIW'(c) == ncm1) begin
        ur = up_row[0];
        cr = cur_row[0];
        dr = dn_row[0];
      end else begin
        ur = up_row[(c + 1) % MAX_COLUMNS];
        cr = cur_row[(c + 1) % MAX_COLUMNS];
        dr = dn_row[(c + 1) % MAX_COLUMNS];
      end
      n = 4'(ul) + 4'(up_row[c]) + 4'(ur) + 4'(cl) + 4'(cr) +
          4'(dl) + 4'(dn_row[c]) + 4'(dr);
      if (!col_mask[c])                 new_row[c] = cur_row[c];
      else if (n == 4'(BIRTH_COUNT))    new_row[c] = 1'b1;
      else if (n == 4'(KEEP_COUNT))     new_row[c] = cur_row[c];
      else                              new_row[c] = 1'b0;
    end
  end

  always_comb begin
    cell_row = rd_data;
    cell_row[CIW'(cur_item.column_index)] = cur_item.cell_live;
  end

  // Memory port selection.
  always_comb begin
    mem_re = 1'b0;
    mem_ra = row_cnt;
    mem_we = 1'b0;
    mem_wa = row_cnt;
    mem_wd = new_row;
    unique case (op)
      OP_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      OP_CELL_RD: begin
        mem_re = 1'b1;
        mem_ra = RIW'(cur_item.row_index);
      end
      OP_CELL_WR: begin
        mem_we = (cur_item.action == ACT_WRITE) && in_grid;
        mem_wa = RIW'(cur_item.row_index);
        mem_wd = cell_row;
      end
      OP_G_RD_LAST: begin
        mem_re = 1'b1;
        mem_ra = nrm1;
      end
      OP_G_RD_FIRST: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      OP_G_RD_NEXT: begin
        mem_re = !status.last_row;
        mem_ra = row_cnt + RIW'(1);
      end
      OP_G_CALC:  mem_we = 1'b1;
      OP_SC_RD:   mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= grid_mem[mem_ra];
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt      <= '0;
      col_cnt      <= '0;
      gen_cnt      <= '0;
      stable_latch <= 1'b0;
      last_change  <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (op)
        OP_CLEAR:  row_cnt <= row_cnt + RIW'(1);
        OP_ACCEPT: row_cnt <= '0;
        OP_G_CALC: col_cnt <= '0;
        OP_G_COUNT: begin
          col_cnt <= col_cnt + CIW'(1);
          if (status.last_col && !status.last_row) row_cnt <= row_cnt + RIW'(1);
        end
        OP_G_FINISH: begin
          row_cnt     <= '0;
          last_change <= chg_cnt;
          if (gen_cnt != '1) gen_cnt <= gen_cnt + GEN_W'(1);
          if (chg_cnt == '0) stable_latch <= 1'b1;
        end
        OP_SC_CHK: row_cnt <= row_cnt + RIW'(1);
        default: ;
      endcase
      if (op == OP_EMIT && status.out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_ACCEPT: begin
        cur_item <= item;
        any_live <= 1'b0;
        cell_val <= 1'b0;
      end
      OP_CELL_WR: begin
        cell_val <= (cur_item.action == ACT_READ) && in_grid &&
                    rd_data[CIW'(cur_item.column_index)];
      end
      OP_G_RD_LAST:  chg_cnt <= '0;
      OP_G_RD_FIRST: up_row <= rd_data;
      OP_G_CUR: begin
        cur_row   <= rd_data;
        first_row <= rd_data;
      end
      OP_G_CALC: begin
        chg_sr  <= new_row ^ cur_row;
        up_row  <= cur_row;
        cur_row <= dn_row;
      end
      OP_G_COUNT: begin
        chg_cnt <= chg_cnt + CHW'(chg_sr[0]);
        chg_sr  <= chg_sr >> 1;
      end
      OP_SC_CHK: any_live <= any_live || (|(rd_data & col_mask));
      OP_EMIT: begin
        if (status.out_free) begin
          result.cell_value       <= cell_val;
          result.generation_count <= gen_cnt;
          result.stable           <= stable_latch;
          result.grid_empty       <= !any_live;
          result.changed_cells    <= CHANGE_W'(last_change);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/toroidal_life_grid_engine.sv
// ----------------------------------------------------------------------------
// toroidal_life_grid_engine
// Conway life grid with wrap-around edges, cell access and generation steps.
// ----------------------------------------------------------------------------
// The block holds a grid of MAX_ROWS by MAX_COLUMNS one-bit cells, of which
// the first row_count rows and column_count columns are in use, and it works
// on one item at a time. A cell write or read reads the addressed row, then
// updates or samples the cell, and is followed by the live cell scan; a
// generation step reads the last and first rows, then for each row takes the
// row below, forms and writes the new row and counts its changed cells one
// column a cycle, and is followed by the scan. The scan that every item ends
// with, to find whether any cell in use is live, reads and then checks one
// grid row at a time. Each result is held in an output register, and the
// next item is taken as soon as the result is loaded. After reset the grid
// memory is cleared one row a cycle with no item accepted; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlge_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlge_pkg::SIZE_W-1:0]      cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  tlge_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output tlge_pkg::result_t                result
);
  import tlge_pkg::*;

  // The controller issues one command per cycle; the datapath reports the
  // row, column and clearing end points and whether the result can be loaded.
  op_t     op;
  status_t status;

  tlge_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_action (item.action),
    .item_ready  (item_ready),
    .status      (status),
    .op          (op)
  );

  tlge_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .op           (op),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // An accepted item keeps the block busy for at least the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while the previous one is in work");

  // Once a result reports a stable grid, no result may report otherwise while result_valid stays high.
  a_stable_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stable |=> !result_valid || result.stable)
    else $error("stable flag cleared");

  // No item is taken while the grid memory is being cleared.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    op == OP_CLEAR |-> !item_ready)
    else $error("item ready during grid clear");

endmodule
